// File: design/afkj_pkg.sv
// ----------------------------------------------------------------------------
// afkj_pkg
// Types, constants and schedule tables of the arm kinematics block.
// ----------------------------------------------------------------------------
package afkj_pkg;

  localparam int ANG_W        = 16;
  localparam int VAL_W        = 32;
  localparam int TRIG_W       = 18;
  localparam int LEN_W        = 16;
  localparam int CFG_IDX_W    = 8;
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_W     = 33;
  localparam int ATAN_W       = 30;
  localparam int AB_W         = 36;
  localparam int PROD_W       = 52;
  localparam int ACC_W        = 54;
  localparam int NUM_ROWS     = 9;
  localparam int NUM_LANES    = 4;
  localparam int NUM_TRIG     = 6;
  localparam int ROW_W        = $clog2(NUM_ROWS);
  localparam int QUEUE_DEPTH  = 2;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [TRIG_W-1:0]   ONE_Q16     = 18'sd65536;
  localparam logic signed [VAL_W-1:0]    NEG_ONE_Q16 = -32'sd65536;
  localparam logic [19:0]                TWO_PI_Q16  = 20'd411775;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LATERAL = 8'd0,
    CFG_UPPER   = 8'd1,
    CFG_FORE    = 8'd2,
    CFG_TOOL    = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LEN_LATERAL,
    LEN_UPPER,
    LEN_FORE,
    LEN_TOOL
  } len_sel_e;

  typedef enum logic [3:0] {
    OP_ZERO, OP_ONE,
    OP_S1, OP_C1, OP_S2, OP_C2, OP_S4, OP_C4,
    OP_S23, OP_C23, OP_S34, OP_C34, OP_S234, OP_C234
  } op_e;

  typedef enum logic [1:0] {
    LK_ACC,
    LK_NEG1,
    LK_ORI
  } lane_kind_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RUN,
    F_DONE
  } front_state_e;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle_0;
    logic signed [ANG_W-1:0] angle_1;
    logic signed [ANG_W-1:0] angle_2;
    logic signed [ANG_W-1:0] angle_3;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              row_kind;
    logic [1:0]              row_index;
    logic signed [VAL_W-1:0] value_0;
    logic signed [VAL_W-1:0] value_1;
    logic signed [VAL_W-1:0] value_2;
    logic signed [VAL_W-1:0] value_3;
    logic                    last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] lateral_offset;
    logic [LEN_W-1:0] upper_link_length;
    logic [LEN_W-1:0] fore_link_length;
    logic [LEN_W-1:0] tool_length;
  } lengths_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s1;
    logic signed [TRIG_W-1:0] c1;
    logic signed [TRIG_W-1:0] s2;
    logic signed [TRIG_W-1:0] c2;
    logic signed [TRIG_W-1:0] s4;
    logic signed [TRIG_W-1:0] c4;
    logic signed [TRIG_W-1:0] s23;
    logic signed [TRIG_W-1:0] c23;
    logic signed [TRIG_W-1:0] s34;
    logic signed [TRIG_W-1:0] c34;
    logic signed [TRIG_W-1:0] s234;
    logic signed [TRIG_W-1:0] c234;
    logic signed [VAL_W-1:0]  ori;
  } trig_set_t;

  typedef struct packed {
    logic     neg;
    len_sel_e len;
    op_e      a;
    op_e      b;
  } term_t;

  // atan(2^-i) in units of a 32-bit turn
  function automatic logic [ATAN_W-1:0] atan_turn(input logic [4:0] i);
    logic [ATAN_W-1:0] r;
    case (i)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10680862;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41722;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2608;
      5'd19:   r = 30'd1304;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic term_t mk(input logic neg, input len_sel_e len, input op_e a,
                               input op_e b);
    term_t t;
    t.neg = neg;
    t.len = len;
    t.a   = a;
    t.b   = b;
    return t;
  endfunction

  // x of the tool point
  function automatic term_t px_term(input logic [1:0] step);
    term_t t;
    case (step)
      2'd0:    t = mk(1'b1, LEN_LATERAL, OP_S1, OP_ONE);
      2'd1:    t = mk(1'b0, LEN_FORE, OP_C23, OP_C1);
      2'd2:    t = mk(1'b0, LEN_UPPER, OP_C1, OP_C2);
      default: t = mk(1'b0, LEN_TOOL, OP_C234, OP_C1);
    endcase
    return t;
  endfunction

  // reach in the arm plane
  function automatic term_t sumc_term(input logic [1:0] step);
    term_t t;
    t = '0;
    case (step)
      2'd0:    t = mk(1'b0, LEN_FORE, OP_C23, OP_ONE);
      2'd1:    t = mk(1'b0, LEN_UPPER, OP_C2, OP_ONE);
      2'd2:    t = mk(1'b0, LEN_TOOL, OP_C234, OP_ONE);
      default: t = '0;
    endcase
    return t;
  endfunction

  // one product term for a given row, column and step
  function automatic term_t sched(input logic [ROW_W-1:0] row, input logic [1:0] lane,
                                  input logic [1:0] step);
    term_t t;
    t = '0;
    case (row)
      4'd0: begin
        case (lane)
          2'd0: t = px_term(step);
          2'd1: begin
            case (step)
              2'd0:    t = mk(1'b0, LEN_LATERAL, OP_C1, OP_ONE);
              2'd1:    t = mk(1'b0, LEN_FORE, OP_C23, OP_S1);
              2'd2:    t = mk(1'b0, LEN_UPPER, OP_C2, OP_S1);
              default: t = mk(1'b0, LEN_TOOL, OP_C234, OP_S1);
            endcase
          end
          2'd2: begin
            case (step)
              2'd0:    t = mk(1'b0, LEN_FORE, OP_S23, OP_ONE);
              2'd1:    t = mk(1'b0, LEN_UPPER, OP_S2, OP_ONE);
              2'd2:    t = mk(1'b0, LEN_TOOL, OP_S234, OP_ONE);
              default: t = '0;
            endcase
          end
          default: t = '0;
        endcase
      end
      4'd1: begin
        case (lane)
          2'd0: begin
            case (step)
              2'd0:    t = mk(1'b1, LEN_LATERAL, OP_C1, OP_ONE);
              2'd1:    t = mk(1'b1, LEN_FORE, OP_C23, OP_S1);
              2'd2:    t = mk(1'b1, LEN_UPPER, OP_C2, OP_S1);
              default: t = mk(1'b1, LEN_TOOL, OP_C234, OP_S1);
            endcase
          end
          2'd1: begin
            case (step)
              2'd0:    t = mk(1'b1, LEN_FORE, OP_S23, OP_C1);
              2'd1:    t = mk(1'b1, LEN_UPPER, OP_S2, OP_C1);
              2'd2:    t = mk(1'b1, LEN_TOOL, OP_S234, OP_C1);
              default: t = '0;
            endcase
          end
          2'd2: begin
            case (step)
              2'd0:    t = mk(1'b1, LEN_FORE, OP_S23, OP_C1);
              2'd1:    t = mk(1'b1, LEN_TOOL, OP_S234, OP_C1);
              default: t = '0;
            endcase
          end
          default: begin
            if (step == 2'd0) t = mk(1'b1, LEN_TOOL, OP_S234, OP_C1);
          end
        endcase
      end
      4'd2: begin
        case (lane)
          2'd0: t = px_term(step);
          2'd1: begin
            case (step)
              2'd0:    t = mk(1'b1, LEN_FORE, OP_S23, OP_S1);
              2'd1:    t = mk(1'b1, LEN_UPPER, OP_S2, OP_S1);
              2'd2:    t = mk(1'b1, LEN_TOOL, OP_S234, OP_S1);
              default: t = '0;
            endcase
          end
          2'd2: begin
            case (step)
              2'd0:    t = mk(1'b1, LEN_FORE, OP_S23, OP_S1);
              2'd1:    t = mk(1'b1, LEN_TOOL, OP_S234, OP_S1);
              default: t = '0;
            endcase
          end
          default: begin
            if (step == 2'd0) t = mk(1'b1, LEN_TOOL, OP_S234, OP_S1);
          end
        endcase
      end
      4'd3: begin
        case (lane)
          2'd1: t = sumc_term(step);
          2'd2: begin
            case (step)
              2'd0:    t = mk(1'b0, LEN_FORE, OP_C23, OP_ONE);
              2'd1:    t = mk(1'b0, LEN_TOOL, OP_C234, OP_ONE);
              default: t = '0;
            endcase
          end
          2'd3: begin
            if (step == 2'd0) t = mk(1'b0, LEN_TOOL, OP_C234, OP_ONE);
          end
          default: t = '0;
        endcase
      end
      4'd5: begin
        case (lane)
          2'd0: begin
            if (step == 2'd0) t = mk(1'b1, LEN_LATERAL, OP_C234, OP_ONE);
          end
          2'd1: begin
            case (step)
              2'd0:    t = mk(1'b0, LEN_UPPER, OP_S34, OP_ONE);
              2'd1:    t = mk(1'b0, LEN_FORE, OP_S4, OP_ONE);
              default: t = '0;
            endcase
          end
          2'd2: begin
            if (step == 2'd0) t = mk(1'b0, LEN_FORE, OP_S4, OP_ONE);
          end
          default: t = '0;
        endcase
      end
      4'd6: begin
        if (lane == 2'd0) t = sumc_term(step);
      end
      4'd7: begin
        case (lane)
          2'd0: begin
            if (step == 2'd0) t = mk(1'b0, LEN_LATERAL, OP_S23, OP_ONE);
          end
          2'd1: begin
            case (step)
              2'd0:    t = mk(1'b0, LEN_TOOL, OP_ONE, OP_ONE);
              2'd1:    t = mk(1'b0, LEN_UPPER, OP_C34, OP_ONE);
              2'd2:    t = mk(1'b0, LEN_FORE, OP_C4, OP_ONE);
              default: t = '0;
            endcase
          end
          2'd2: begin
            case (step)
              2'd0:    t = mk(1'b0, LEN_TOOL, OP_ONE, OP_ONE);
              2'd1:    t = mk(1'b0, LEN_FORE, OP_C4, OP_ONE);
              default: t = '0;
            endcase
          end
          default: begin
            if (step == 2'd0) t = mk(1'b0, LEN_TOOL, OP_ONE, OP_ONE);
          end
        endcase
      end
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic lane_kind_e lane_kind(input logic [ROW_W-1:0] row,
                                           input logic [1:0] lane);
    lane_kind_e k;
    k = LK_ACC;
    if ((row == 4'd4 || row == 4'd8) && lane != 2'd0) k = LK_NEG1;
    if (row == 4'd0 && lane == 2'd3) k = LK_ORI;
    return k;
  endfunction

  function automatic logic [1:0] row_kind_of(input logic [ROW_W-1:0] row);
    logic [1:0] k;
    if (row == 4'd0)     k = 2'd0;
    else if (row < 4'd5) k = 2'd1;
    else                 k = 2'd2;
    return k;
  endfunction

  function automatic logic [1:0] row_index_of(input logic [ROW_W-1:0] row);
    logic [ROW_W-1:0] r;
    if (row == 4'd0)     r = '0;
    else if (row < 4'd5) r = row - 4'd1;
    else                 r = row - 4'd5;
    return r[1:0];
  endfunction

endpackage

// File: design/arm_forward_kinematics_jacobian.sv
// ----------------------------------------------------------------------------
// arm_forward_kinematics_jacobian
// Forward kinematics and Jacobians of a four-axis arm, nine rows per set.
// ----------------------------------------------------------------------------
//  channel   signals                                    request moves
//  input     push / full, in_data_i                         four joint angles
//  result    pop / empty, out_data_o                        one row of four Q16.16
//  config    cfg_valid_i / cfg_ready_o, index, data     one link length
//
//  front: per angle set a load, 20 CORDIC iterations and a hand-off,
//  six trig lanes in parallel; a new set is taken once the last one is queued.
//  back: per row 4 issue phases, 2 multiply stages and an emit phase, nine rows
//  per set; one multiply chain per column, and a new row starts once the last is emitted.
//  reset clears control state and sets all lengths to 0; no clearing pass.
//  a full output register stalls the back only; the front keeps filling the queue.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_jacobian import afkj_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_data_i,
  input  logic                 pop,
  output logic                 empty,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEN_W-1:0]     cfg_data_i
);

  lengths_t  len_q;
  logic      q_push, q_full, q_pop, q_empty;
  trig_set_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LATERAL: len_q.lateral_offset    <= cfg_data_i;
        CFG_UPPER:   len_q.upper_link_length <= cfg_data_i;
        CFG_FORE:    len_q.fore_link_length  <= cfg_data_i;
        CFG_TOOL:    len_q.tool_length       <= cfg_data_i;
        default:     len_q <= len_q;
      endcase
    end
  end

  afkj_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .in_i     (in_data_i),
    .q_push_o (q_push),
    .q_full_i (q_full),
    .q_data_o (q_wdata)
  );

  afkj_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  afkj_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .len_i     (len_q),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_o     (out_data_o)
  );

endmodule

// File: design/afkj_front.sv
// ----------------------------------------------------------------------------
// afkj_front
// Takes an angle set, runs six CORDIC lanes and hands the trig set on.
// ----------------------------------------------------------------------------
module afkj_front import afkj_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  in_item_t  in_i,
  output logic      q_push_o,
  input  logic      q_full_i,
  output trig_set_t q_data_o
);

  front_state_e state_q, state_d;
  logic [4:0]   step_q, step_d;
  logic         load, iterate;

  logic signed [CORDIC_W-1:0] x_q [NUM_TRIG];
  logic signed [CORDIC_W-1:0] y_q [NUM_TRIG];
  logic signed [CORDIC_W-1:0] z_q [NUM_TRIG];
  logic                       flip_q [NUM_TRIG];
  logic signed [VAL_W-1:0]    ori_q;

  logic [ANG_W-1:0]           ang [NUM_TRIG];
  logic signed [TRIG_W-1:0]   cs [NUM_TRIG];
  logic signed [TRIG_W-1:0]   sn [NUM_TRIG];
  logic signed [CORDIC_W-1:0] atan_v;
  logic signed [17:0]         ang_sum;
  logic signed [18:0]         ang_neg;
  logic signed [39:0]         ori_prod;
  logic signed [39:0]         ori_rnd;

  // round to Q16, clamp to one, undo the half-turn fold
  function automatic logic signed [TRIG_W-1:0] finish(input logic signed [CORDIC_W-1:0] v,
                                                      input logic flip);
    logic signed [CORDIC_W-1:0] r;
    logic signed [TRIG_W-1:0]   c;
    r = (v + 33'sd8192) >>> 14;
    if (r > 33'sd65536)       c = ONE_Q16;
    else if (r < -33'sd65536) c = -ONE_Q16;
    else                      c = r[TRIG_W-1:0];
    return flip ? -c : c;
  endfunction

  always_comb begin
    ang[0] = in_i.angle_0;
    ang[1] = in_i.angle_1;
    ang[2] = in_i.angle_3;
    ang[3] = in_i.angle_1 + in_i.angle_2;
    ang[4] = in_i.angle_2 + in_i.angle_3;
    ang[5] = in_i.angle_1 + in_i.angle_2 + in_i.angle_3;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (push_i) state_d = F_RUN;
      F_RUN:   if (step_q == 5'(CORDIC_STEPS - 1)) state_d = F_DONE;
      F_DONE:  if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full_o   = 1'b1;
    load     = 1'b0;
    iterate  = 1'b0;
    q_push_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        full_o = 1'b0;
        load   = push_i;
      end
      F_RUN:   iterate = 1'b1;
      F_DONE:  q_push_o = !q_full_i;
      default: full_o = 1'b1;
    endcase
  end

  assign step_d = load ? 5'd0 : (iterate ? step_q + 5'd1 : step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign atan_v = CORDIC_W'(atan_turn(step_q));

  // orientation: negated sum of the three pitch joints, not wrapped
  assign ang_sum  = 18'(in_i.angle_1) + 18'(in_i.angle_2) + 18'(in_i.angle_3);
  assign ang_neg  = -19'(ang_sum);
  assign ori_prod = 40'(ang_neg) * 40'(signed'({1'b0, TWO_PI_Q16}));
  assign ori_rnd  = (ori_prod + 40'sd32768) >>> 16;

  always_ff @(posedge clk_i) begin
    if (load) ori_q <= ori_rnd[VAL_W-1:0];
    for (int l = 0; l < NUM_TRIG; l++) begin
      if (load) begin
        x_q[l]    <= CORDIC_GAIN;
        y_q[l]    <= '0;
        flip_q[l] <= ang[l][15] ^ ang[l][14];
        z_q[l]    <= signed'({ang[l][14], ang[l][15] ^
                              (ang[l][15] ^ ang[l][14]), ang[l][14:0], 16'h0000});
      end else if (iterate) begin
        if (z_q[l] >= 0) begin
          x_q[l] <= x_q[l] - (y_q[l] >>> step_q);
          y_q[l] <= y_q[l] + (x_q[l] >>> step_q);
          z_q[l] <= z_q[l] - atan_v;
        end else begin
          x_q[l] <= x_q[l] + (y_q[l] >>> step_q);
          y_q[l] <= y_q[l] - (x_q[l] >>> step_q);
          z_q[l] <= z_q[l] + atan_v;
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_TRIG; l++) begin
      cs[l] = finish(x_q[l], flip_q[l]);
      sn[l] = finish(y_q[l], flip_q[l]);
    end
    q_data_o.s1   = sn[0];
    q_data_o.c1   = cs[0];
    q_data_o.s2   = sn[1];
    q_data_o.c2   = cs[1];
    q_data_o.s4   = sn[2];
    q_data_o.c4   = cs[2];
    q_data_o.s23  = sn[3];
    q_data_o.c23  = cs[3];
    q_data_o.s34  = sn[4];
    q_data_o.c34  = cs[4];
    q_data_o.s234 = sn[5];
    q_data_o.c234 = cs[5];
    q_data_o.ori  = ori_q;
  end

endmodule

// File: design/afkj_queue.sv
// ----------------------------------------------------------------------------
// afkj_queue
// Short queue of trig sets between front and back.
// ----------------------------------------------------------------------------
module afkj_queue import afkj_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  trig_set_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output trig_set_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  trig_set_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// File: design/afkj_back.sv
// ----------------------------------------------------------------------------
// afkj_back
// Row sequencer: four multiply-accumulate lanes, rounding and output register.
// ----------------------------------------------------------------------------
module afkj_back import afkj_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lengths_t  len_i,
  input  logic      q_empty_i,
  input  trig_set_t q_data_i,
  output logic      q_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t out_o
);

  localparam logic [2:0] PHASE_EMIT = 3'd6;

  logic [ROW_W-1:0] row_q, row_d;
  logic [2:0]       phase_q, phase_d;
  logic             active, emit, can_load;
  logic             out_valid_q;
  out_item_t        out_q, out_d;

  term_t                     term [NUM_LANES];
  logic signed [AB_W-1:0]    ab_q [NUM_LANES];
  logic [LEN_W-1:0]          len_q [NUM_LANES];
  logic                      neg_q [NUM_LANES];
  logic signed [PROD_W-1:0]  prod_q [NUM_LANES];
  logic signed [ACC_W-1:0]   acc_q [NUM_LANES];
  logic signed [VAL_W-1:0]   val [NUM_LANES];

  function automatic logic signed [TRIG_W-1:0] opval(input op_e op, input trig_set_t t);
    logic signed [TRIG_W-1:0] v;
    case (op)
      OP_ONE:  v = ONE_Q16;
      OP_S1:   v = t.s1;
      OP_C1:   v = t.c1;
      OP_S2:   v = t.s2;
      OP_C2:   v = t.c2;
      OP_S4:   v = t.s4;
      OP_C4:   v = t.c4;
      OP_S23:  v = t.s23;
      OP_C23:  v = t.c23;
      OP_S34:  v = t.s34;
      OP_C34:  v = t.c34;
      OP_S234: v = t.s234;
      OP_C234: v = t.c234;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [LEN_W-1:0] lenval(input len_sel_e s, input lengths_t l);
    logic [LEN_W-1:0] v;
    case (s)
      LEN_LATERAL: v = l.lateral_offset;
      LEN_UPPER:   v = l.upper_link_length;
      LEN_FORE:    v = l.fore_link_length;
      default:     v = l.tool_length;
    endcase
    return v;
  endfunction

  // round half up from 36 fraction bits to 16, saturate to 32 bits
  function automatic logic signed [VAL_W-1:0] to_q16(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    logic signed [VAL_W-1:0] v;
    r = (a + (ACC_W'(1) <<< 19)) >>> 20;
    if (r > ACC_W'(32'sh7fffffff))       v = 32'sh7fffffff;
    else if (r < -ACC_W'(33'sh80000000)) v = 32'sh80000000;
    else                                 v = r[VAL_W-1:0];
    return v;
  endfunction

  assign active   = !q_empty_i;
  assign can_load = !out_valid_q || pop_i;
  assign emit     = active && phase_q == PHASE_EMIT && can_load;
  assign q_pop_o  = emit && row_q == ROW_W'(NUM_ROWS - 1);

  always_comb begin
    row_d   = row_q;
    phase_d = phase_q;
    if (emit) begin
      phase_d = '0;
      row_d   = (row_q == ROW_W'(NUM_ROWS - 1)) ? '0 : row_q + 1'b1;
    end else if (active && phase_q != PHASE_EMIT) begin
      phase_d = phase_q + 3'd1;
    end
  end

  // one term per lane in each of the first four phases of a row
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      term[l] = '0;
      if (active && !phase_q[2]) term[l] = sched(row_q, 2'(l), phase_q[1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      ab_q[l]   <= opval(term[l].a, q_data_i) * opval(term[l].b, q_data_i);
      len_q[l]  <= lenval(term[l].len, len_i);
      neg_q[l]  <= term[l].neg;
      prod_q[l] <= neg_q[l] ? -(PROD_W'(signed'({1'b0, len_q[l]})) * PROD_W'(ab_q[l]))
                            :  (PROD_W'(signed'({1'b0, len_q[l]})) * PROD_W'(ab_q[l]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LANES; l++) acc_q[l] <= '0;
    end else begin
      for (int l = 0; l < NUM_LANES; l++) begin
        acc_q[l] <= emit ? '0 : acc_q[l] + ACC_W'(prod_q[l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      case (lane_kind(row_q, 2'(l)))
        LK_NEG1: val[l] = NEG_ONE_Q16;
        LK_ORI:  val[l] = q_data_i.ori;
        default: val[l] = to_q16(acc_q[l]);
      endcase
    end
    out_d.row_kind    = row_kind_of(row_q);
    out_d.row_index   = row_index_of(row_q);
    out_d.value_0     = val[0];
    out_d.value_1     = val[1];
    out_d.value_2     = val[2];
    out_d.value_3     = val[3];
    out_d.last_of_run = row_q == ROW_W'(NUM_ROWS - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_q   <= row_d;
      phase_q <= phase_d;
      if (emit)        out_valid_q <= 1'b1;
      else if (pop_i)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= out_d;
  end

  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

`ifndef SYNTHESIS
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < ROW_W'(NUM_ROWS)) else $error("row counter out of range");
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PHASE_EMIT) else $error("phase counter out of range");
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q) else $error("emitted row not shown");
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> row_q == '0 && phase_q == '0) else $error("set retired mid run");
`endif

endmodule
